### rtl/cns_pkg.sv
// ----------------------------------------------------------------------------
// cns_pkg
// Types and constants shared by the comma separated name splitter.
// ----------------------------------------------------------------------------
package cns_pkg;

  localparam int unsigned MaxNameLen = 64;
  localparam int unsigned BufDepth   = MaxNameLen - 1;
  localparam int unsigned AddrW      = $clog2(BufDepth);
  localparam int unsigned LenW       = $clog2(MaxNameLen + 1);

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharComma = 8'h2C;

  localparam logic [7:0] MaxNamesReset = 8'd8;

  localparam logic KindName    = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } cns_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [7:0] name_index;
    logic       last_in_run;
    logic [7:0] name_count;
    logic       too_long;
  } cns_out_t;

endpackage

### rtl/cns_name_ram.sv
// ----------------------------------------------------------------------------
// cns_name_ram
// Name buffer: one write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module cns_name_ram
  import cns_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [BufDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/csv_name_splitter_top.sv
// ----------------------------------------------------------------------------
// csv_name_splitter_top
// Splits a byte stream at commas into trimmed names, with an end summary.
// ----------------------------------------------------------------------------
// Input items carry one text byte or an end-of-text mark. Output items are
// name bytes (kind 0), replayed from the name buffer when a comma or the end
// of text closes a name, and one summary (kind 1) per text with the name
// count and the too-long flag. The user must write max_names over the cfg
// channel only while the block is idle; the block itself does not enforce it.
// cfg_ready_o is always high. A byte that closes no name is taken without
// stalling the input. A comma that closes a kept name stalls the input while
// the name is replayed from the buffer: each name byte passes a buffer read
// state (ST_RD), then an output load state (ST_EMIT). An end-of-text item
// adds a summary state (ST_SUM) after any replay; name bytes and summaries
// leave through the output register.
// The output register holds an item until out_stall_i is low; while it is
// stalled, replay waits and the input stays stalled until replay is done.
// After reset the name buffer content is unknown but never read before it is
// written, all per-text state is zero, and max_names is 8.
// ----------------------------------------------------------------------------
module csv_name_splitter_top
  import cns_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cns_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cns_out_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_SUM  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]       max_names_q;
  logic [LenW-1:0]  raw_len_q, raw_len_d;
  logic [LenW-1:0]  trim_len_q, trim_len_d;
  logic             inside_q, inside_d;
  logic [7:0]       done_q, done_d;
  logic             err_q, err_d;
  logic [LenW-1:0]  rep_len_q, rep_len_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic             rep_eot_q, rep_eot_d;
  logic             out_valid_q, out_valid_d;
  cns_out_t         out_q, out_d;

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;
  logic             re;
  logic [7:0]       rdata;

  logic in_acc;
  logic out_free;
  logic is_blank;
  logic can_flush;
  logic rep_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_names_q <= MaxNamesReset;
    end else if (cfg_valid_i) begin
      max_names_q <= cfg_data_i;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_blank   = (in_data_i.char_code == CharSpace) ||
                      (in_data_i.char_code == CharTab);
  assign can_flush  = !err_q && (trim_len_q != '0) && (done_q < max_names_q);
  assign rep_last   = ({1'b0, rd_idx_q} + LenW'(1)) == rep_len_q;

  cns_name_ram u_name_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    raw_len_d   = raw_len_q;
    trim_len_d  = trim_len_q;
    inside_d    = inside_q;
    done_d      = done_q;
    err_d       = err_q;
    rep_len_d   = rep_len_q;
    rd_idx_d    = rd_idx_q;
    rep_eot_d   = rep_eot_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = raw_len_q[AddrW-1:0];
    wdata       = in_data_i.char_code;
    re          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.end_of_text) begin
            raw_len_d  = '0;
            trim_len_d = '0;
            inside_d   = 1'b0;
            rep_eot_d  = 1'b1;
            if (can_flush) begin
              rep_len_d = trim_len_q;
              rd_idx_d  = '0;
              state_d   = ST_RD;
            end else begin
              state_d = ST_SUM;
            end
          end else if (err_q || (done_q >= max_names_q)) begin
            // Bytes are dropped until the end of text.
          end else if (in_data_i.char_code == CharComma) begin
            raw_len_d  = '0;
            trim_len_d = '0;
            inside_d   = 1'b0;
            rep_eot_d  = 1'b0;
            if (can_flush) begin
              rep_len_d = trim_len_q;
              rd_idx_d  = '0;
              state_d   = ST_RD;
            end
          end else if (is_blank) begin
            if (inside_q) begin
              if (raw_len_q < LenW'(BufDepth)) begin
                we        = 1'b1;
                raw_len_d = raw_len_q + LenW'(1);
              end else begin
                // Mark the buffer as overrun so the next non-blank errors.
                raw_len_d = LenW'(MaxNameLen);
              end
            end
          end else if (raw_len_q >= LenW'(BufDepth)) begin
            err_d      = 1'b1;
            raw_len_d  = '0;
            trim_len_d = '0;
            inside_d   = 1'b0;
          end else begin
            we         = 1'b1;
            raw_len_d  = raw_len_q + LenW'(1);
            trim_len_d = raw_len_q + LenW'(1);
            inside_d   = 1'b1;
          end
        end
      end

      ST_RD: begin
        re      = 1'b1;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.kind        = KindName;
          out_d.out_byte    = rdata;
          out_d.name_index  = done_q;
          out_d.last_in_run = !rep_eot_q && rep_last;
          out_d.name_count  = done_q + 8'd1;
          out_d.too_long    = 1'b0;
          if (rep_last) begin
            done_d  = done_q + 8'd1;
            state_d = rep_eot_q ? ST_SUM : ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + AddrW'(1);
            state_d  = ST_RD;
          end
        end
      end

      ST_SUM: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.kind        = KindSummary;
          out_d.out_byte    = '0;
          out_d.name_index  = '0;
          out_d.last_in_run = 1'b1;
          out_d.name_count  = done_q;
          out_d.too_long    = err_q;
          done_d            = '0;
          err_d             = 1'b0;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      raw_len_q   <= '0;
      trim_len_q  <= '0;
      inside_q    <= 1'b0;
      done_q      <= '0;
      err_q       <= 1'b0;
      rep_len_q   <= '0;
      rd_idx_q    <= '0;
      rep_eot_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      raw_len_q   <= raw_len_d;
      trim_len_q  <= trim_len_d;
      inside_q    <= inside_d;
      done_q      <= done_d;
      err_q       <= err_d;
      rep_len_q   <= rep_len_d;
      rd_idx_q    <= rd_idx_d;
      rep_eot_q   <= rep_eot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Once an error is flagged, no partial name is kept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (raw_len_q == '0) && !inside_q && (trim_len_q == '0))
    else $error("name state not cleared after error");

  // A replay always covers a non-empty name that fits the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |->
      (rep_len_q != '0) && (rep_len_q <= LenW'(BufDepth)) &&
      ({1'b0, rd_idx_q} < rep_len_q))
    else $error("replay index out of range");

  // A name byte is consistent with its index and never flags an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KindName) |->
      (out_data_o.name_count == out_data_o.name_index + 8'd1) &&
      !out_data_o.too_long)
    else $error("name byte fields inconsistent");

  // A summary closes the run of results of its input item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KindSummary) |->
      out_data_o.last_in_run && (out_data_o.out_byte == '0))
    else $error("summary fields malformed");

  // The trimmed length never runs ahead of the held bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    trim_len_q <= raw_len_q)
    else $error("trimmed length exceeds raw length");
`endif

endmodule
